>>> rtl/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion shorthands for the sphere cull RTL.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every clock edge outside reset.
`define OFSC_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) else $error(msg);

// Check a property on every clock edge, reset included.
`define OFSC_ASSERT_RST(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) (prop)) else $error(msg);

`endif

>>> rtl/ofsc_pkg.sv
// ---------------------------------------------------------------------------
// ofsc_pkg
// Types and constants shared by the orthographic sphere cull modules.
// ---------------------------------------------------------------------------
package ofsc_pkg;

    // Field widths
    localparam int POS_W   = 20;   // signed Q12.8 position
    localparam int COEF_W  = 18;   // signed Q4.14 coefficient
    localparam int RAD_W   = 19;   // unsigned Q11.8 radius
    localparam int ROW_W   = 3 * COEF_W;
    localparam int VEC_W   = 3 * POS_W;
    localparam int FRAC_SH = 14;   // coefficient fraction bits

    // Internal widths
    localparam int PROD_W  = POS_W + COEF_W;          // one product, Q.22
    localparam int SUM_W   = PROD_W + 2;              // three products plus offset
    localparam int VIEW_W  = SUM_W - FRAC_SH;         // view coordinate, Q.8
    localparam int DIFF_W  = VIEW_W + 1;              // distance to box per axis
    localparam int SQ_W    = 2 * DIFF_W;              // squared axis distance
    localparam int DIST_W  = SQ_W + 2;                // sum of three squares
    localparam int RSQ_W   = 2 * RAD_W;               // radius squared

    // Port widths
    localparam int S_DATA_W = 80;
    localparam int M_DATA_W = 8;
    localparam int CFG_IDX_W = 3;

    // Register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_VIEW_ROW_X   = 3'd0,
        REG_VIEW_ROW_Y   = 3'd1,
        REG_VIEW_ROW_Z   = 3'd2,
        REG_VIEW_OFFSET  = 3'd3,
        REG_BOX_LOW      = 3'd4,
        REG_BOX_HIGH     = 3'd5
    } cfg_index_t;

    // Register reset values: identity rows, zero offset and box
    localparam logic [ROW_W-1:0] VIEW_ROW_X_RST = 54'd16384;
    localparam logic [ROW_W-1:0] VIEW_ROW_Y_RST = 54'd4294967296;
    localparam logic [ROW_W-1:0] VIEW_ROW_Z_RST = 54'd1125899906842624;

    typedef struct packed {
        logic [ROW_W-1:0] view_row_x;
        logic [ROW_W-1:0] view_row_y;
        logic [ROW_W-1:0] view_row_z;
        logic [VEC_W-1:0] view_offset;
        logic [VEC_W-1:0] box_low_corner;
        logic [VEC_W-1:0] box_high_corner;
    } cfg_regs_t;

    // One sphere as accepted
    typedef struct packed {
        logic [RAD_W-1:0]        sphere_radius;
        logic signed [POS_W-1:0] center_z;
        logic signed [POS_W-1:0] center_y;
        logic signed [POS_W-1:0] center_x;
    } sphere_t;

    // One sphere moved into view space
    typedef struct packed {
        logic [RAD_W-1:0]         sphere_radius;
        logic signed [VIEW_W-1:0] view_z;
        logic signed [VIEW_W-1:0] view_y;
        logic signed [VIEW_W-1:0] view_x;
    } view_item_t;

endpackage

>>> rtl/ofsc_queue.sv
// ---------------------------------------------------------------------------
// ofsc_queue
// Small register FIFO between the transform front and the test back end.
// ---------------------------------------------------------------------------
module ofsc_queue #(
    parameter int DEPTH = 4,
    parameter int WIDTH = 97
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             in_valid,
    output logic             in_ready,
    input  logic [WIDTH-1:0] in_data,
    output logic             out_valid,
    input  logic             out_ready,
    output logic [WIDTH-1:0] out_data
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             wr_en, rd_en;

    assign in_ready  = (count_reg != CNT_W'(DEPTH));
    assign out_valid = (count_reg != '0);
    assign out_data  = mem_reg[rd_ptr_reg];
    assign wr_en     = in_valid && in_ready;
    assign rd_en     = out_valid && out_ready;

    // Advance pointers with wrap and track fill level
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (wr_en) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (rd_en) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        unique case ({wr_en, rd_en})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store entry data
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_ptr_reg] <= in_data;
        end
    end

endmodule

>>> rtl/ofsc_front.sv
// ---------------------------------------------------------------------------
// ofsc_front
// Accepts spheres and moves the center into view space in two stages.
// ---------------------------------------------------------------------------
module ofsc_front
    import ofsc_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  cfg_regs_t  cfg,
    input  logic       in_valid,
    output logic       in_ready,
    input  sphere_t    in_item,
    output logic       q_valid,
    input  logic       q_ready,
    output view_item_t q_item
);

    logic signed [POS_W-1:0]  ctr    [3];
    logic [ROW_W-1:0]         row    [3];
    logic signed [COEF_W-1:0] cf     [3][3];
    logic signed [POS_W-1:0]  off    [3];
    logic signed [SUM_W-1:0]  offs   [3];
    logic signed [SUM_W-1:0]  sum    [3];
    logic signed [PROD_W-1:0] prod_next [3][3];
    logic signed [PROD_W-1:0] prod_reg  [3][3];
    logic [RAD_W-1:0]         rad1_reg;
    logic                     v1_reg;
    logic                     v2_reg;
    view_item_t               item2_reg, item2_next;
    logic                     st1_ready, st2_ready;

    assign st2_ready = !v2_reg || q_ready;
    assign st1_ready = !v1_reg || st2_ready;
    assign in_ready  = st1_ready;
    assign q_valid   = v2_reg;
    assign q_item    = item2_reg;

    // Stage 1: nine coefficient products, input i into view axis j
    always_comb begin
        ctr[0] = in_item.center_x;
        ctr[1] = in_item.center_y;
        ctr[2] = in_item.center_z;
        row[0] = cfg.view_row_x;
        row[1] = cfg.view_row_y;
        row[2] = cfg.view_row_z;
        for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
                cf[i][j]        = row[i][COEF_W*j +: COEF_W];
                prod_next[i][j] = ctr[i] * cf[i][j];
            end
        end
    end

    // Stage 2: add products and offset, floor to Q.8 by dropping fraction bits
    always_comb begin
        for (int j = 0; j < 3; j++) begin
            off[j]  = cfg.view_offset[POS_W*j +: POS_W];
            offs[j] = {{(SUM_W - POS_W - FRAC_SH){off[j][POS_W-1]}}, off[j],
                       {FRAC_SH{1'b0}}};
            sum[j]  = prod_reg[0][j] + prod_reg[1][j] + prod_reg[2][j] + offs[j];
        end
        item2_next.view_x        = sum[0][SUM_W-1:FRAC_SH];
        item2_next.view_y        = sum[1][SUM_W-1:FRAC_SH];
        item2_next.view_z        = sum[2][SUM_W-1:FRAC_SH];
        item2_next.sphere_radius = rad1_reg;
    end

    // Hold valid flags per stage
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end else begin
            if (st1_ready) begin
                v1_reg <= in_valid;
            end
            if (st2_ready) begin
                v2_reg <= v1_reg;
            end
        end
    end

    // Advance payload when the stage moves
    always_ff @(posedge aclk) begin
        if (st1_ready) begin
            prod_reg <= prod_next;
            rad1_reg <= in_item.sphere_radius;
        end
        if (st2_ready) begin
            item2_reg <= item2_next;
        end
    end

endmodule

>>> rtl/ofsc_back.sv
// ---------------------------------------------------------------------------
// ofsc_back
// Far-z and box distance test on view-space spheres; drives the result.
// ---------------------------------------------------------------------------
module ofsc_back
    import ofsc_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  cfg_regs_t  cfg,
    input  logic       q_valid,
    output logic       q_ready,
    input  view_item_t q_item,
    output logic       out_valid,
    input  logic       out_ready,
    output logic       out_visible
);

    logic signed [VIEW_W-1:0] vv     [3];
    logic signed [POS_W-1:0]  lo     [3];
    logic signed [POS_W-1:0]  hi     [3];
    logic signed [DIFF_W-1:0] a_next [3];
    logic signed [DIFF_W-1:0] a_reg  [3];
    logic signed [DIFF_W:0]   zdiff;
    logic                     far_next, far1_reg, far2_reg;
    logic [RAD_W-1:0]         rad1_reg;
    logic [SQ_W-1:0]          sq_next [3];
    logic [SQ_W-1:0]          sq_reg  [3];
    logic [RSQ_W-1:0]         rsq_next, rsq_reg;
    logic [DIST_W-1:0]        dist_sum;
    logic                     vis_next;
    logic                     v1_reg, v2_reg, out_valid_reg, out_visible_reg;
    logic                     st1_ready, st2_ready, st3_ready;

    assign st3_ready   = !out_valid_reg || out_ready;
    assign st2_ready   = !v2_reg || st3_ready;
    assign st1_ready   = !v1_reg || st2_ready;
    assign q_ready     = st1_ready;
    assign out_valid   = out_valid_reg;
    assign out_visible = out_visible_reg;

    // Stage 1: far-z check and per-axis clamp distance; lower bound wins
    always_comb begin
        vv[0] = q_item.view_x;
        vv[1] = q_item.view_y;
        vv[2] = q_item.view_z;
        for (int j = 0; j < 3; j++) begin
            lo[j] = cfg.box_low_corner[POS_W*j +: POS_W];
            hi[j] = cfg.box_high_corner[POS_W*j +: POS_W];
            if (vv[j] < lo[j]) begin
                a_next[j] = vv[j] - lo[j];
            end else if (vv[j] > hi[j]) begin
                a_next[j] = vv[j] - hi[j];
            end else begin
                a_next[j] = '0;
            end
        end
        zdiff    = q_item.view_z - $signed({1'b0, q_item.sphere_radius});
        far_next = (zdiff > hi[2]);
    end

    // Stage 2: squares of the axis distances and of the radius
    always_comb begin
        for (int j = 0; j < 3; j++) begin
            sq_next[j] = a_reg[j] * a_reg[j];
        end
        rsq_next = rad1_reg * rad1_reg;
    end

    // Stage 3: sum squares and compare; touching counts as visible
    always_comb begin
        dist_sum = DIST_W'(sq_reg[0]) + DIST_W'(sq_reg[1]) + DIST_W'(sq_reg[2]);
        vis_next = !far2_reg && (dist_sum <= DIST_W'(rsq_reg));
    end

    // Hold valid flags per stage
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (st1_ready) begin
                v1_reg <= q_valid;
            end
            if (st2_ready) begin
                v2_reg <= v1_reg;
            end
            if (st3_ready) begin
                out_valid_reg <= v2_reg;
            end
        end
    end

    // Advance payload when the stage moves
    always_ff @(posedge aclk) begin
        if (st1_ready) begin
            a_reg    <= a_next;
            far1_reg <= far_next;
            rad1_reg <= q_item.sphere_radius;
        end
        if (st2_ready) begin
            sq_reg   <= sq_next;
            rsq_reg  <= rsq_next;
            far2_reg <= far1_reg;
        end
        if (st3_ready) begin
            out_visible_reg <= vis_next;
        end
    end

endmodule

>>> rtl/ortho_frustum_sphere_cull_unit.sv
// ---------------------------------------------------------------------------
// ortho_frustum_sphere_cull_unit
// Orthographic view-box sphere cull: affine view transform, far-z reject and
// clamped squared-distance test against the view-space box.
// ---------------------------------------------------------------------------
// The unit takes one sphere per cycle and returns one visible bit for each,
// in order. A front part of two stages (nine 20x18 multipliers, then the
// wide sum and floor to Q.8) feeds a QUEUE_DEPTH-entry FIFO; a back part of
// three stages (clamp and far-z check, three 27x27 squares plus radius
// squared, then sum and compare) drains it into the output register. Every
// stage takes a new item each cycle while the output is not stalled, so the
// sustained rate is one sphere per cycle. Up to QUEUE_DEPTH + 5 spheres can
// be in flight. Configuration writes are always ready and must only be
// issued while no sphere is pending.
`include "assert_macros.svh"

module ortho_frustum_sphere_cull_unit
    import ofsc_pkg::*;
#(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    // center_x[19:0], center_y[39:20], center_z[59:40], sphere_radius[78:60]
    input  logic [S_DATA_W-1:0]  s_tdata,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // visible[0]
    output logic [M_DATA_W-1:0]  m_tdata,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [VEC_W-1:0]     cfg_data
);

    localparam int PEND_CAP = QUEUE_DEPTH + 5;
    localparam int PEND_W   = $clog2(PEND_CAP + 1);

    cfg_regs_t        cfg_reg, cfg_next;
    sphere_t          in_item;
    view_item_t       fq_item, qb_item;
    logic             fq_valid, fq_ready, qb_valid, qb_ready;
    logic             out_visible;
    logic [PEND_W-1:0] pend_reg, pend_next;
    logic             s_acc, m_acc;

    assign cfg_ready = 1'b1;
    assign in_item   = sphere_t'(s_tdata[$bits(sphere_t)-1:0]);
    assign m_tdata   = {{(M_DATA_W - 1){1'b0}}, out_visible};

    // Decode configuration writes; unknown indexes are dropped
    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                REG_VIEW_ROW_X:  cfg_next.view_row_x      = cfg_data[ROW_W-1:0];
                REG_VIEW_ROW_Y:  cfg_next.view_row_y      = cfg_data[ROW_W-1:0];
                REG_VIEW_ROW_Z:  cfg_next.view_row_z      = cfg_data[ROW_W-1:0];
                REG_VIEW_OFFSET: cfg_next.view_offset     = cfg_data;
                REG_BOX_LOW:     cfg_next.box_low_corner  = cfg_data;
                REG_BOX_HIGH:    cfg_next.box_high_corner = cfg_data;
                default:         cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.view_row_x      <= VIEW_ROW_X_RST;
            cfg_reg.view_row_y      <= VIEW_ROW_Y_RST;
            cfg_reg.view_row_z      <= VIEW_ROW_Z_RST;
            cfg_reg.view_offset     <= '0;
            cfg_reg.box_low_corner  <= '0;
            cfg_reg.box_high_corner <= '0;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    // Transform front
    ofsc_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg      (cfg_reg),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .in_item  (in_item),
        .q_valid  (fq_valid),
        .q_ready  (fq_ready),
        .q_item   (fq_item)
    );

    // Decoupling queue
    ofsc_queue #(
        .DEPTH (QUEUE_DEPTH),
        .WIDTH ($bits(view_item_t))
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (fq_valid),
        .in_ready  (fq_ready),
        .in_data   (fq_item),
        .out_valid (qb_valid),
        .out_ready (qb_ready),
        .out_data  (qb_item)
    );

    // Test back end
    ofsc_back u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg         (cfg_reg),
        .q_valid     (qb_valid),
        .q_ready     (qb_ready),
        .q_item      (qb_item),
        .out_valid   (m_tvalid),
        .out_ready   (m_tready),
        .out_visible (out_visible)
    );

    // Track spheres accepted but not yet delivered
    assign s_acc = s_tvalid && s_tready;
    assign m_acc = m_tvalid && m_tready;

    always_comb begin
        pend_next = pend_reg;
        unique case ({s_acc, m_acc})
            2'b10:   pend_next = pend_reg + 1'b1;
            2'b01:   pend_next = pend_reg - 1'b1;
            default: pend_next = pend_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pend_reg <= '0;
        end else begin
            pend_reg <= pend_next;
        end
    end

    // Assertions
    `OFSC_ASSERT(a_pend_cap, pend_reg <= PEND_W'(PEND_CAP), "more spheres in flight than storage")
    `OFSC_ASSERT(a_out_has_item, m_tvalid |-> (pend_reg != '0), "result without pending sphere")
    `OFSC_ASSERT(a_idle_ready, (pend_reg == '0) |-> s_tready, "empty unit refuses input")
    `OFSC_ASSERT_RST(a_reset_clears, !aresetn |=> !m_tvalid, "result valid after reset")

endmodule
